// ----- src/fgd_pkg.sv -----
// Shared types and constants for the FSK Goertzel demodulator.
// Used by the register file, the multiplier, the core and the top level.
`timescale 1ns / 1ps
package fgd_pkg;

	// Field widths
	localparam int COEFF_W  = 18;
	localparam int SPB_W    = 12;
	localparam int SAMPLE_W = 16;
	localparam int BYTE_W   = 8;

	// Default widths of the resonator taps and the energy sums
	localparam int RES_W_DEF = 40;
	localparam int EN_W_DEF  = 64;

	// Shared multiplier operand width and the taps' power scale (31 bits)
	localparam int MUL_W = 33;
	localparam int PWR_W = 31;

	// APB side
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Register indexes
	localparam logic [1:0] REG_MARK_COEFF  = 2'd0;
	localparam logic [1:0] REG_SPACE_COEFF = 2'd1;
	localparam logic [1:0] REG_SPB         = 2'd2;

	// Register reset values
	localparam logic signed [COEFF_W-1:0] MARK_COEFF_RST  = -18'sd117555;
	localparam logic signed [COEFF_W-1:0] SPACE_COEFF_RST = -18'sd108988;
	localparam logic [SPB_W-1:0]          SPB_RST         = 12'd480;

	typedef struct packed {
		logic signed [COEFF_W-1:0] mark_coeff;
		logic signed [COEFF_W-1:0] space_coeff;
		logic [SPB_W-1:0]          bit_len;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MQL,
		ST_MQH,
		ST_ACC,
		ST_SUM,
		ST_SAT,
		ST_MCR,
		ST_MR0,
		ST_MR1,
		ST_MTR,
		ST_PSUB,
		ST_EN,
		ST_BIT
	} state_t;

endpackage

// ----- src/fgd_apb_regs.sv -----
// APB register file: mark and space coefficients and the bit window length.
// Depends on fgd_pkg for the register map and reset values.
`timescale 1ns / 1ps
module fgd_apb_regs import fgd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_coeff  <= MARK_COEFF_RST;
			cfg_q.space_coeff <= SPACE_COEFF_RST;
			cfg_q.bit_len     <= SPB_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MARK_COEFF:  cfg_q.mark_coeff  <= pwdata[COEFF_W-1:0];
				REG_SPACE_COEFF: cfg_q.space_coeff <= pwdata[COEFF_W-1:0];
				REG_SPB:         cfg_q.bit_len     <= pwdata[SPB_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register bits
	always_comb begin
		case (reg_idx)
			REG_MARK_COEFF:  prdata = APB_DW'(unsigned'(cfg_q.mark_coeff));
			REG_SPACE_COEFF: prdata = APB_DW'(unsigned'(cfg_q.space_coeff));
			REG_SPB:         prdata = APB_DW'(cfg_q.bit_len);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- src/fgd_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on fgd_pkg for the operand width.
`timescale 1ns / 1ps
module fgd_mul import fgd_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_W-1:0]   a,
	input  logic signed [MUL_W-1:0]   b,
	output logic signed [2*MUL_W-1:0] prod_q
);

	// Register every product; the sequencer reads it in the step after it drives the operands
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ----- src/fgd_core.sv -----
// Sequencer and datapath: two Goertzel resonators, energy sums, bit and byte assembly.
// Depends on fgd_pkg; drives the shared multiplier fgd_mul.
`timescale 1ns / 1ps
module fgd_core import fgd_pkg::*; #(
	parameter int RESONATOR_WIDTH = RES_W_DEF,
	parameter int ENERGY_WIDTH    = EN_W_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SAMPLE_W-1:0]  in_sample,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [BYTE_W-1:0]           out_data,
	output logic signed [MUL_W-1:0]     mul_a,
	output logic signed [MUL_W-1:0]     mul_b,
	input  logic signed [2*MUL_W-1:0]   mul_p
);

	localparam int RW  = RESONATOR_WIDTH;
	localparam int EW  = ENERGY_WIDTH;
	localparam int AW  = RW + 19;
	localparam int SW  = RW + 4;
	localparam int PW  = 2 * MUL_W;
	localparam int XW  = 66;
	localparam int RSH = RW - PWR_W;

	localparam logic signed [SW-1:0] RMAX = (SW'(1) <<< (RW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] RMIN = -RMAX - SW'(1);
	localparam logic signed [XW-1:0] EMAX = (XW'(1) <<< (EW - 1)) - XW'(1);
	localparam logic signed [XW-1:0] EMIN = -EMAX - XW'(1);

	state_t state_q, state_d;

	logic                       tone_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic signed [RW-1:0]       recent_q [2];
	logic signed [RW-1:0]       prev_q   [2];
	logic signed [EW-1:0]       energy_q [2];
	logic signed [AW-1:0]       acc_q;
	logic signed [SW-1:0]       sum_q;
	logic signed [PWR_W-1:0]    r0_q, r1_q;
	logic signed [MUL_W-1:0]    t_q;
	logic signed [63:0]         pow_q;
	logic [SPB_W-1:0]           wc_q;
	logic [2:0]                 pos_q;
	logic [BYTE_W-1:0]          shift_q;
	logic                       out_valid_q;
	logic [BYTE_W-1:0]          out_data_q;

	logic signed [COEFF_W-1:0]  coeff;
	logic signed [RW-1:0]       q1, q2;
	logic signed [RW+32:0]      q1x;
	logic signed [MUL_W-1:0]    q1_lo, q1_hi;
	logic signed [AW-1:0]       prod_aw;
	logic signed [RW-1:0]       q0;
	logic signed [XW-1:0]       en_sum;
	logic signed [EW-1:0]       en_next;
	logic [SPB_W-1:0]           wc_next;
	logic                       win_close;
	logic                       bit_val;
	logic [BYTE_W-1:0]          shift_next;
	logic                       emit;
	logic                       bit_go;

	// Select the active tone's coefficient and taps
	assign coeff   = tone_q ? cfg.space_coeff : cfg.mark_coeff;
	assign q1      = recent_q[tone_q];
	assign q2      = prev_q[tone_q];
	assign q1x     = (RW + 33)'(q1);
	assign q1_lo   = {1'b0, q1[31:0]};
	assign q1_hi   = q1x[64:32];
	assign prod_aw = AW'(mul_p);

	// Clamp the new tap to the resonator range
	always_comb begin
		if (sum_q > RMAX) begin
			q0 = RW'(RMAX);
		end else if (sum_q < RMIN) begin
			q0 = RW'(RMIN);
		end else begin
			q0 = RW'(sum_q);
		end
	end

	// Saturating energy accumulate
	assign en_sum = XW'(energy_q[tone_q]) + XW'(pow_q);
	always_comb begin
		if (en_sum > EMAX) begin
			en_next = EW'(EMAX);
		end else if (en_sum < EMIN) begin
			en_next = EW'(EMIN);
		end else begin
			en_next = EW'(en_sum);
		end
	end

	// Window close, bit decision and byte completion
	assign wc_next    = wc_q + SPB_W'(1);
	assign win_close  = (wc_next >= cfg.bit_len);
	assign bit_val    = (energy_q[0] > energy_q[1]);
	assign shift_next = {shift_q[BYTE_W-2:0], bit_val};
	assign emit       = win_close && (pos_q == 3'd7);
	assign bit_go     = !(emit && out_valid_q && !out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MQL;
				end
			end
			ST_MQL: begin
				mul_a   = MUL_W'(coeff);
				mul_b   = q1_lo;
				state_d = ST_MQH;
			end
			ST_MQH: begin
				mul_a   = MUL_W'(coeff);
				mul_b   = q1_hi;
				state_d = ST_ACC;
			end
			ST_ACC: state_d = ST_SUM;
			ST_SUM: state_d = ST_SAT;
			ST_SAT: state_d = ST_MCR;
			ST_MCR: begin
				mul_a   = MUL_W'(coeff);
				mul_b   = MUL_W'(r0_q);
				state_d = ST_MR0;
			end
			ST_MR0: begin
				mul_a   = MUL_W'(r0_q);
				mul_b   = MUL_W'(r0_q);
				state_d = ST_MR1;
			end
			ST_MR1: begin
				mul_a   = MUL_W'(r1_q);
				mul_b   = MUL_W'(r1_q);
				state_d = ST_MTR;
			end
			ST_MTR: begin
				mul_a   = t_q;
				mul_b   = MUL_W'(r1_q);
				state_d = ST_PSUB;
			end
			ST_PSUB: state_d = ST_EN;
			ST_EN: begin
				state_d = tone_q ? ST_BIT : ST_MQL;
			end
			ST_BIT: begin
				if (bit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working registers of the shared datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= in_sample;
				last_q   <= in_last;
			end
			ST_MQH:  acc_q <= prod_aw + AW'(32768);
			ST_ACC:  acc_q <= acc_q + (prod_aw <<< 32);
			ST_SUM:  sum_q <= SW'(acc_q >>> 16) + SW'(sample_q) - SW'(q2);
			ST_SAT: begin
				r0_q <= PWR_W'(q0 >>> RSH);
				r1_q <= PWR_W'(q1 >>> RSH);
			end
			ST_MR0:  t_q   <= MUL_W'((mul_p + PW'(32768)) >>> 16);
			ST_MR1:  pow_q <= 64'(mul_p);
			ST_MTR:  pow_q <= pow_q + 64'(mul_p);
			ST_PSUB: pow_q <= pow_q - 64'(mul_p);
			default: ;
		endcase
	end

	// Resonator taps, energies, window and byte state, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q      <= 1'b0;
			wc_q        <= '0;
			pos_q       <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int i = 0; i < 2; i++) begin
				recent_q[i] <= '0;
				prev_q[i]   <= '0;
				energy_q[i] <= '0;
			end
		end else begin
			// Load a finished byte, or drop the beat once the sink takes it
			if ((state_q == ST_BIT) && bit_go && emit) begin
				out_valid_q <= 1'b1;
				out_data_q  <= shift_next;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: tone_q <= 1'b0;
				ST_SAT: begin
					prev_q[tone_q]   <= q1;
					recent_q[tone_q] <= q0;
				end
				ST_EN: begin
					energy_q[tone_q] <= en_next;
					tone_q           <= 1'b1;
				end
				ST_BIT: begin
					if (bit_go) begin
						// Advance the window count, or restart it on close or last sample
						if (win_close || last_q) begin
							wc_q <= '0;
						end else begin
							wc_q <= wc_next;
						end
						// Shift in the bit; a full byte or the last sample empties the register
						if (emit || last_q) begin
							shift_q <= '0;
							pos_q   <= '0;
						end else if (win_close) begin
							shift_q <= shift_next;
							pos_q   <= pos_q + 3'd1;
						end
						// Close the window or drop everything on the last sample
						if (win_close || last_q) begin
							for (int i = 0; i < 2; i++) begin
								recent_q[i] <= '0;
								prev_q[i]   <= '0;
								energy_q[i] <= '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- src/fsk_goertzel_demodulator.sv -----
// Binary FSK demodulator: mark and space Goertzel resonators on one shared multiplier.
// Each sample is accepted only in the idle state and then runs through 11 sequencer
// steps per tone on the single 33x33 multiplier and one bit/byte step before the next.
// A completed byte is registered in the bit/byte step of the sample that closes it; a
// waiting byte stalls the sequencer only when the next byte is due. Asynchronous reset
// clears all taps, energies, window and byte state and loads the register defaults.
`timescale 1ns / 1ps
module fsk_goertzel_demodulator import fgd_pkg::*; #(
	parameter int RESONATOR_WIDTH = RES_W_DEF,
	parameter int ENERGY_WIDTH    = EN_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Sample stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [15:0] sample
	input  logic              s_axis_tlast,   // last_sample
	// Byte stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // [7:0] data_byte
	// Configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t                    cfg;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	fgd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fgd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (mul_p)
	);

	fgd_core #(
		.RESONATOR_WIDTH (RESONATOR_WIDTH),
		.ENERGY_WIDTH    (ENERGY_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_p     (mul_p)
	);

endmodule
